// ----- hdl/hrr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hrr_pkg
// Types, constants and character helpers for the HEX record relocator.
// ----------------------------------------------------------------------------
package hrr_pkg;

   localparam int HRR_MAX_DATA = 16;
   localparam int CH_W         = 8;
   localparam int OFFSET_W     = 16;
   localparam int STATUS_W     = 3;

   localparam logic [CH_W-1:0] CHAR_COLON = 8'h3a;
   localparam logic [CH_W-1:0] CHAR_NL    = 8'h0a;
   localparam logic [CH_W-1:0] CHAR_NUL   = 8'h00;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_DONE     = 3'd1,
      ST_BADSUM   = 3'd2,
      ST_BADDIGIT = 3'd3,
      ST_EARLYEND = 3'd4,
      ST_TOOLONG  = 3'd5
   } status_type;

   // {valid, value}
   function automatic logic [4:0] hex_value(input logic [CH_W-1:0] c);
      logic [CH_W-1:0] d;
      logic            ok;
      d  = CHAR_NUL;
      ok = 1'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d  = c - 8'h30;
         ok = 1'b1;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d  = c - 8'h57;
         ok = 1'b1;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d  = c - 8'h37;
         ok = 1'b1;
      end
      return {ok, d[3:0]};
   endfunction

   // lower-case ASCII for one nibble
   function automatic logic [CH_W-1:0] hex_char(input logic [3:0] n);
      logic [CH_W-1:0] c;
      if (n < 4'ha) begin
         c = 8'h30 + {4'h0, n};
      end else begin
         c = 8'h57 + {4'h0, n};
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/hex_record_relocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hex_record_relocator
// Parses Intel HEX text, checks each record and re-emits it with a shifted
// load address and a fresh checksum, one character per item.
// ----------------------------------------------------------------------------
//  channel | direction | tdata             | tuser      | tlast
//  req_    | in        | [7:0] ch          | -          | end_of_input
//  rsp_    | out       | [7:0] out_char    | [2:0] status | last
//  csr_    | in        | [15:0] address_offset (write only)
//
//  Parsing takes one input item per cycle while the output is not stalled.
//  The character after a good checksum starts the emit sequencer, which
//  produces 2*length+12 output items at one per cycle while rsp_tready is
//  high, taking no input until it finishes. One output register sits on rsp_;
//  a stalled sink stalls the sequencer. Reset clears all control state; after
//  an error or a non-data record the block drops all input until reset.
// ----------------------------------------------------------------------------
module hex_record_relocator
   import hrr_pkg::*;
#(
   parameter int MAX_DATA = HRR_MAX_DATA
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [CH_W-1:0]     req_tdata,   // [7:0] ch
   input  wire logic                req_tlast,   // end_of_input
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [CH_W-1:0]          rsp_tdata,   // [7:0] out_char
   output logic [STATUS_W-1:0]      rsp_tuser,   // [2:0] status
   output logic                     rsp_tlast,   // last
   input  wire logic                csr_we,
   input  wire logic [OFFSET_W-1:0] csr_wdata    // [15:0] address_offset
);

   localparam int IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
   localparam int CNT_W = $clog2(MAX_DATA + 1);
   localparam logic [7:0] LEN_MAX = 8'(MAX_DATA);

   typedef enum logic [3:0] {
      P_COLON, P_LEN, P_ADDR, P_KIND, P_DATA, P_SUM, P_TAIL, P_EMIT, P_HALT
   } phase_type;

   typedef enum logic [1:0] {E_COLON, E_HI, E_LO, E_NL} emit_type;

   typedef enum logic [2:0] {B_LEN, B_AHI, B_ALO, B_KIND, B_DATA, B_SUM} byte_type;

   phase_type             phase_ff, phase_in;
   emit_type              emit_ff, emit_in;
   byte_type              bsel_ff, bsel_in;
   logic                  nib_odd_ff, nib_odd_in;
   logic                  addr_byte_ff, addr_byte_in;
   logic [7:0]            len_ff, len_in;
   logic [15:0]           addr_ff, addr_in;
   logic [7:0]            kind_ff, kind_in;
   logic [7:0]            sum_ff, sum_in;
   logic [3:0]            hi_nib_ff, hi_nib_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [OFFSET_W-1:0]   offset_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]       char_ff, char_in;
   status_type            status_ff, status_in;
   logic                  last_ff, last_in;
   logic [7:0]            rd_data_ff;
   logic [7:0]            mem [MAX_DATA];

   logic                  accept;
   logic                  out_free;
   logic [4:0]            digit;
   logic [7:0]            byte_in;
   logic [7:0]            emit_byte;
   logic [15:0]           new_addr;
   logic [7:0]            sum_add;
   logic [CNT_W-1:0]      idx_p1;
   logic                  last_data;
   logic                  wr_en;
   status_type            rec_status;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (phase_ff == P_HALT) || (phase_ff != P_EMIT && out_free);
   assign accept     = req_tvalid && req_tready;
   assign digit      = hex_value(req_tdata);
   assign byte_in    = {hi_nib_ff, digit[3:0]};
   assign new_addr   = addr_ff + offset_ff;
   assign idx_p1     = idx_ff + 1'b1;
   assign last_data  = (8'(idx_ff) + 8'd1) == len_ff;
   assign rec_status = (kind_ff != 8'h00) ? ST_DONE : ST_OK;
   assign sum_add    = sum_ff + ((phase_ff == P_EMIT) ? emit_byte : byte_in);

   always_comb begin
      unique case (bsel_ff)
         B_LEN:   emit_byte = len_ff;
         B_AHI:   emit_byte = new_addr[15:8];
         B_ALO:   emit_byte = new_addr[7:0];
         B_KIND:  emit_byte = kind_ff;
         B_DATA:  emit_byte = rd_data_ff;
         B_SUM:   emit_byte = (~sum_ff) + 8'd1;
         default: emit_byte = 8'h00;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      emit_in      = emit_ff;
      bsel_in      = bsel_ff;
      nib_odd_in   = nib_odd_ff;
      addr_byte_in = addr_byte_ff;
      len_in       = len_ff;
      addr_in      = addr_ff;
      kind_in      = kind_ff;
      sum_in       = sum_ff;
      hi_nib_in    = hi_nib_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      char_in      = char_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      wr_en        = 1'b0;

      unique case (phase_ff)
         P_COLON: begin
            if (accept) begin
               if (req_tlast) begin
                  rsp_valid_in = 1'b1;
                  char_in      = CHAR_NUL;
                  status_in    = ST_EARLYEND;
                  last_in      = 1'b1;
                  phase_in     = P_HALT;
               end else if (req_tdata == CHAR_COLON) begin
                  sum_in     = 8'h00;
                  nib_odd_in = 1'b0;
                  phase_in   = P_LEN;
               end
            end
         end
         P_LEN, P_ADDR, P_KIND, P_DATA, P_SUM: begin
            if (accept) begin
               if (req_tlast || !digit[4]) begin
                  rsp_valid_in = 1'b1;
                  char_in      = CHAR_NUL;
                  status_in    = req_tlast ? ST_EARLYEND : ST_BADDIGIT;
                  last_in      = 1'b1;
                  phase_in     = P_HALT;
               end else if (!nib_odd_ff) begin
                  hi_nib_in  = digit[3:0];
                  nib_odd_in = 1'b1;
               end else begin
                  nib_odd_in = 1'b0;
                  sum_in     = sum_add;
                  unique case (phase_ff)
                     P_LEN: begin
                        len_in = byte_in;
                        if (byte_in > LEN_MAX) begin
                           rsp_valid_in = 1'b1;
                           char_in      = CHAR_NUL;
                           status_in    = ST_TOOLONG;
                           last_in      = 1'b1;
                           phase_in     = P_HALT;
                        end else begin
                           addr_byte_in = 1'b0;
                           phase_in     = P_ADDR;
                        end
                     end
                     P_ADDR: begin
                        addr_in      = {addr_ff[7:0], byte_in};
                        addr_byte_in = 1'b1;
                        if (addr_byte_ff) begin
                           phase_in = P_KIND;
                        end
                     end
                     P_KIND: begin
                        kind_in  = byte_in;
                        idx_in   = '0;
                        phase_in = (len_ff != 8'h00) ? P_DATA : P_SUM;
                     end
                     P_DATA: begin
                        wr_en = 1'b1;
                        if (last_data) begin
                           phase_in = P_SUM;
                        end else begin
                           idx_in = idx_p1;
                        end
                     end
                     default: begin
                        phase_in = P_TAIL;
                     end
                  endcase
               end
            end
         end
         P_TAIL: begin
            if (accept) begin
               idx_in  = '0;
               bsel_in = B_LEN;
               emit_in = E_COLON;
               sum_in  = 8'h00;
               if (sum_ff != 8'h00) begin
                  rsp_valid_in = 1'b1;
                  char_in      = CHAR_NUL;
                  status_in    = ST_BADSUM;
                  last_in      = 1'b1;
                  phase_in     = P_HALT;
               end else begin
                  phase_in = P_EMIT;
               end
            end
         end
         P_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = rec_status;
               last_in      = 1'b0;
               unique case (emit_ff)
                  E_COLON: begin
                     char_in = CHAR_COLON;
                     emit_in = E_HI;
                  end
                  E_HI: begin
                     char_in = hex_char(emit_byte[7:4]);
                     emit_in = E_LO;
                  end
                  E_LO: begin
                     char_in = hex_char(emit_byte[3:0]);
                     sum_in  = sum_add;
                     emit_in = E_HI;
                     unique case (bsel_ff)
                        B_LEN:  bsel_in = B_AHI;
                        B_AHI:  bsel_in = B_ALO;
                        B_ALO:  bsel_in = B_KIND;
                        B_KIND: bsel_in = (len_ff != 8'h00) ? B_DATA : B_SUM;
                        B_DATA: begin
                           if (last_data) begin
                              bsel_in = B_SUM;
                           end else begin
                              idx_in = idx_p1;
                           end
                        end
                        default: emit_in = E_NL;
                     endcase
                  end
                  default: begin
                     char_in  = CHAR_NL;
                     last_in  = 1'b1;
                     phase_in = (kind_ff != 8'h00) ? P_HALT : P_COLON;
                  end
               endcase
            end
         end
         P_HALT: begin
         end
         default: begin
            phase_in = P_COLON;
         end
      endcase
   end

   // data buffer, registered read one step ahead of the emit pointer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff[IDX_W-1:0]] <= byte_in;
      end
      rd_data_ff <= mem[idx_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= P_COLON;
         emit_ff      <= E_COLON;
         bsel_ff      <= B_LEN;
         nib_odd_ff   <= 1'b0;
         addr_byte_ff <= 1'b0;
         sum_ff       <= 8'h00;
         idx_ff       <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         emit_ff      <= emit_in;
         bsel_ff      <= bsel_in;
         nib_odd_ff   <= nib_odd_in;
         addr_byte_ff <= addr_byte_in;
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            offset_ff <= csr_wdata;
         end
      end
      len_ff    <= len_in;
      addr_ff   <= addr_in;
      kind_ff   <= kind_in;
      hi_nib_ff <= hi_nib_in;
      char_ff   <= char_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

// ----- verif/tb_hex_record_relocator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hex_record_relocator
// Self-checking bench for the HEX record relocator. A short table of records
// (extremes, mixed case, junk, odd trailers) is followed by random well-formed
// records with random pacing on both channels and address offset changes
// between records. The run ends with one randomly chosen halting event (end
// record or one of the errors) and a few items the halted block must drop.
// Every output item is checked against a local parser model or a typed result.
// ----------------------------------------------------------------------------
module tb_hex_record_relocator
   import hrr_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int ITEM_TARGET    = 390;
   localparam int DIR_ROWS       = 8;

   typedef struct packed {
      logic            eoi;
      logic [CH_W-1:0] ch;
   } req_item_type;

   typedef struct packed {
      logic [CH_W-1:0] ch;
      status_type      st;
      logic            last;
   } out_item_type;

   typedef enum logic [2:0] {
      AT_COLON, AT_LEN, AT_ADDR, AT_KIND, AT_DATA, AT_SUM, AT_TAIL
   } parse_type;

   typedef enum int {
      HALT_END_RECORD, HALT_BAD_SUM, HALT_BAD_DIGIT, HALT_EOI_IN_HEX,
      HALT_EOI_AT_COLON, HALT_TOO_LONG
   } halt_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [CH_W-1:0]     req_tdata  = '0;
   logic                req_tlast  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [CH_W-1:0]     rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;
   logic                rsp_tlast;
   logic                csr_we     = 1'b0;
   logic [OFFSET_W-1:0] csr_wdata  = '0;

   // directed records: offset in force, one lead character, record text
   // (last character is the trailer), trailer sent as end of input, typed result
   logic [OFFSET_W-1:0] dir_offset [DIR_ROWS] = '{
      16'h0000, 16'hffff, 16'hffff, 16'h1234, 16'h1234, 16'h0001, 16'h0001, 16'h8000
   };
   logic [CH_W-1:0] dir_lead [DIR_ROWS] = '{
      8'h00, 8'hff, 8'h78, 8'h3b, 8'h80, 8'h7f, 8'h41, 8'h20
   };
   string dir_text [DIR_ROWS] = '{
      ":0000000000\n",
      ":00FFFF0002\015",
      ":1000000000FF55AA0102feDCba9876543210A5c34f\n",
      ":01ABCD007710:",
      ":02fffe00a55a02x",
      ":00FFFF0002\n",
      ":0401230045AbCdEf2C\015",
      "#\011:0000000000g"
   };
   bit dir_tail_eoi [DIR_ROWS] = '{0, 0, 0, 0, 1, 0, 0, 0};
   string dir_expect [DIR_ROWS] = '{
      ":0000000000\n", ":00fffe0003\n", "", "", "", "", "", ""
   };

   string        hex_digits = "0123456789abcdef";
   out_item_type out_q [$];
   req_item_type burst_q [$];
   int           error_count = 0;
   int           sent_count  = 0;
   int           quiet_cycles = 0;
   bit           calm = 1'b0;
   bit           typed_row = 1'b0;

   // parser model
   parse_type       pphase       = AT_COLON;
   int              nib_cnt      = 0;
   logic [7:0]      rec_len      = '0;
   logic [7:0]      rec_kind     = '0;
   logic [7:0]      byte_sum     = '0;
   logic [15:0]     load_addr    = '0;
   logic [15:0]     offset_model = '0;
   logic [7:0]      rec_bytes [HRR_MAX_DATA];
   logic [3:0]      hi_nib       = '0;
   bit              stopped      = 1'b0;

   hex_record_relocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 36);
   end

   // {ok, value}
   function automatic logic [4:0] digit_of(input logic [7:0] c);
      logic [7:0] lc;
      logic [7:0] d;
      lc = c | 8'h20;
      if (c >= "0" && c <= "9") begin
         d = c - "0";
         return {1'b1, d[3:0]};
      end
      if (lc >= "a" && lc <= "f") begin
         d = lc - 8'h57;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

   function automatic void put_out(input logic [7:0] c, input status_type st,
                                   input logic last);
      if (!typed_row) out_q.push_back({c, st, last});
   endfunction

   function automatic void put_hex(input logic [7:0] b, input status_type st);
      put_out(hex_digits[b[7:4]], st, 1'b0);
      put_out(hex_digits[b[3:0]], st, 1'b0);
   endfunction

   function automatic void reject(input status_type code);
      put_out(CHAR_NUL, code, 1'b1);
      stopped = 1'b1;
   endfunction

   function automatic void model_emit();
      status_type  st;
      logic [15:0] a;
      logic [7:0]  sum;
      st  = (rec_kind != 8'h00) ? ST_DONE : ST_OK;
      a   = load_addr + offset_model;
      sum = rec_len + a[15:8] + a[7:0] + rec_kind;
      put_out(CHAR_COLON, st, 1'b0);
      put_hex(rec_len, st);
      put_hex(a[15:8], st);
      put_hex(a[7:0], st);
      put_hex(rec_kind, st);
      for (int i = 0; i < rec_len; i++) begin
         put_hex(rec_bytes[i], st);
         sum = sum + rec_bytes[i];
      end
      put_hex(8'h00 - sum, st);
      put_out(CHAR_NL, st, 1'b1);
   endfunction

   function automatic void model_char(input logic [7:0] c, input logic eoi);
      logic [4:0] dv;
      logic [7:0] b;
      int         idx;
      if (stopped) return;
      if (pphase == AT_TAIL) begin
         pphase  = AT_COLON;
         nib_cnt = 0;
         if (byte_sum != 8'h00) begin
            reject(ST_BADSUM);
         end else begin
            model_emit();
            if (rec_kind != 8'h00) stopped = 1'b1;
         end
         return;
      end
      if (pphase == AT_COLON) begin
         if (eoi) begin
            reject(ST_EARLYEND);
         end else if (c == CHAR_COLON) begin
            byte_sum = '0;
            nib_cnt  = 0;
            pphase   = AT_LEN;
         end
         return;
      end
      if (eoi) begin
         reject(ST_EARLYEND);
         return;
      end
      dv = digit_of(c);
      if (!dv[4]) begin
         reject(ST_BADDIGIT);
         return;
      end
      if (nib_cnt % 2 == 0) begin
         hi_nib = dv[3:0];
         nib_cnt++;
         return;
      end
      b        = {hi_nib, dv[3:0]};
      byte_sum = byte_sum + b;
      nib_cnt++;
      case (pphase)
         AT_LEN: begin
            rec_len = b;
            if (b > HRR_MAX_DATA) begin
               reject(ST_TOOLONG);
            end else begin
               nib_cnt = 0;
               pphase  = AT_ADDR;
            end
         end
         AT_ADDR: begin
            load_addr = {load_addr[7:0], b};
            if (nib_cnt >= 4) begin
               nib_cnt = 0;
               pphase  = AT_KIND;
            end
         end
         AT_KIND: begin
            rec_kind = b;
            nib_cnt  = 0;
            pphase   = (rec_len != 8'h00) ? AT_DATA : AT_SUM;
         end
         AT_DATA: begin
            idx            = nib_cnt / 2 - 1;
            rec_bytes[idx] = b;
            if (idx + 1 >= rec_len) begin
               nib_cnt = 0;
               pphase  = AT_SUM;
            end
         end
         default: begin
            nib_cnt = 0;
            pphase  = AT_TAIL;
         end
      endcase
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      c = rand_byte();
      while (c == CHAR_COLON) c = rand_byte();
      return c;
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      c = rand_byte();
      while (digit_of(c) != 5'd0) c = rand_byte();
      return c;
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      logic [7:0] c;
      for (int i = 1; i >= 0; i--) begin
         c = hex_digits[b[i*4 +: 4]];
         if (c >= "a" && $urandom_range(1)) c = c - 8'h20;
         burst_q.push_back({1'b0, c});
      end
   endfunction

   function automatic void build_record(input logic [7:0] len, input logic [15:0] addr,
                                        input logic [7:0] kind, input logic [7:0] sum_err);
      logic [7:0] sum;
      logic [7:0] b;
      burst_q.push_back({1'b0, CHAR_COLON});
      add_byte(len);
      add_byte(addr[15:8]);
      add_byte(addr[7:0]);
      add_byte(kind);
      sum = len + addr[15:8] + addr[7:0] + kind;
      for (int i = 0; i < len; i++) begin
         b = rand_byte();
         add_byte(b);
         sum = sum + b;
      end
      add_byte((8'h00 - sum) ^ sum_err);
   endfunction

   function automatic req_item_type trailer();
      int pick;
      pick = $urandom_range(9);
      if (pick < 5) return {1'b0, CHAR_NL};
      if (pick < 7) return {1'b0, 8'h0d};
      if (pick < 9) return {1'b0, rand_byte()};
      return {1'b1, rand_byte()};
   endfunction

   task automatic send_item(input req_item_type it);
      if (!calm) begin
         while ($urandom_range(99) < 36) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it.ch;
      req_tlast  <= it.eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      model_char(it.ch, it.eoi);
   endtask

   task automatic send_burst();
      foreach (burst_q[i]) send_item(burst_q[i]);
      burst_q.delete();
   endtask

   // offset may only change with the block idle
   task automatic settle_and_write(input logic [OFFSET_W-1:0] v);
      req_tvalid <= 1'b0;
      while (out_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we       <= 1'b0;
      offset_model  = v;
   endtask

   always @(posedge clock) begin : check_out
      out_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (out_q.size() == 0) begin
            $error("unexpected item: out_char %h status %0d last %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            want = out_q.pop_front();
            if (rsp_tdata !== want.ch) begin
               $error("out_char: expected %h, got %h", want.ch, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== want.st) begin
               $error("status: expected %0d, got %0d", want.st, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int       rec_no;
      int       cut;
      halt_type halt_kind;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      settle_and_write(16'h0000);

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_offset[i] != offset_model) settle_and_write(dir_offset[i]);
         typed_row = (dir_expect[i].len() != 0);
         send_item({1'b0, dir_lead[i]});
         for (int j = 0; j < dir_text[i].len(); j++) begin
            send_item({dir_tail_eoi[i] && (j == dir_text[i].len() - 1), dir_text[i][j]});
         end
         if (typed_row) begin
            for (int k = 0; k < dir_expect[i].len(); k++) begin
               out_q.push_back({dir_expect[i][k], ST_OK,
                                1'(k == dir_expect[i].len() - 1)});
            end
         end
         typed_row = 1'b0;
      end

      rec_no = 0;
      while (sent_count < ITEM_TARGET) begin
         if (rec_no % 6 == 5) begin
            case ($urandom_range(3))
               0:       settle_and_write(16'h0000);
               1:       settle_and_write(16'hffff);
               default: settle_and_write(16'($urandom));
            endcase
         end
         calm = (rec_no >= 1 && rec_no < 5);
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(3, 1)) burst_q.push_back({1'b0, junk_char()});
         end
         build_record(8'($urandom_range(HRR_MAX_DATA)), 16'($urandom), 8'h00, 8'h00);
         burst_q.push_back(trailer());
         send_burst();
         rec_no++;
      end
      calm = 1'b0;

      // one halting event, then items the block must drop
      halt_kind = halt_type'($urandom_range(5));
      case (halt_kind)
         HALT_END_RECORD: begin
            build_record(8'($urandom_range(HRR_MAX_DATA)), 16'($urandom),
                         8'($urandom_range(255, 1)), 8'h00);
            burst_q.push_back(trailer());
         end
         HALT_BAD_SUM: begin
            build_record(8'($urandom_range(HRR_MAX_DATA)), 16'($urandom), 8'h00,
                         8'($urandom_range(255, 1)));
            burst_q.push_back(trailer());
         end
         HALT_BAD_DIGIT, HALT_EOI_IN_HEX: begin
            build_record(8'($urandom_range(HRR_MAX_DATA)), 16'($urandom), 8'h00, 8'h00);
            cut = int'($urandom_range(burst_q.size() - 1, 1));
            while (burst_q.size() > cut) void'(burst_q.pop_back());
            if (halt_kind == HALT_BAD_DIGIT) burst_q.push_back({1'b0, non_hex_char()});
            else burst_q.push_back({1'b1, rand_byte()});
         end
         HALT_EOI_AT_COLON: begin
            burst_q.push_back({1'b1, rand_byte()});
         end
         default: begin
            burst_q.push_back({1'b0, CHAR_COLON});
            add_byte(8'($urandom_range(255, HRR_MAX_DATA + 1)));
            repeat (4) burst_q.push_back({1'b0, rand_byte()});
         end
      endcase
      send_burst();
      repeat (6) burst_q.push_back({1'($urandom_range(1)), rand_byte()});
      send_burst();
      req_tvalid <= 1'b0;

      while (out_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/hrr_pkg.sv
hdl/hex_record_relocator.sv
verif/tb_hex_record_relocator.sv
